// ----- rtl/core/bbd_pkg.sv -----
// Shared constants, types and register codes of the bank bit debouncer.
`default_nettype none

package bbd_pkg;

	// Default geometry
	localparam int BANKS_DEF         = 5;
	localparam int BITS_PER_BANK_DEF = 32;

	// Field widths
	localparam int BANK_W    = 3;
	localparam int WORD_W    = 32;
	localparam int TIME_W    = 32;
	localparam int HOLD_W    = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd10;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRESS_HOLD   = 2'd0,
		REG_RELEASE_HOLD = 2'd1
	} reg_idx_t;

	// Control shared by every bit lane while a transaction is resolved
	typedef struct packed {
		logic              fire;
		logic [TIME_W-1:0] now;
		logic [HOLD_W-1:0] press_hold;
		logic [HOLD_W-1:0] release_hold;
	} lane_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/bbd_ram.sv -----
// Generic single write port RAM with registered read.
`default_nettype none

module bbd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 5
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/bbd_lane.sv -----
// One bit lane: press and release timestamps of one button in every bank.
`default_nettype none

module bbd_lane #(
	parameter int BANKS = bbd_pkg::BANKS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire bbd_pkg::lane_ctl_t                     ctl,
	input  wire logic                                   clr,
	input  wire logic [(BANKS > 1 ? $clog2(BANKS) : 1)-1:0] clr_addr,
	input  wire logic                                   rd_en,
	input  wire logic [(BANKS > 1 ? $clog2(BANKS) : 1)-1:0] rd_addr,
	input  wire logic [(BANKS > 1 ? $clog2(BANKS) : 1)-1:0] wr_addr,
	input  wire logic                                   cur,
	input  wire logic                                   old,
	input  wire logic                                   deb_old,
	output logic                                        deb_new
);

	localparam int AW = (BANKS > 1) ? $clog2(BANKS) : 1;

	logic                      prs_we, rel_we;
	logic                      prs_ram_we, rel_ram_we;
	logic [AW-1:0]             ram_waddr;
	logic [bbd_pkg::TIME_W-1:0] ram_wdata;
	logic [bbd_pkg::TIME_W-1:0] prs_rd, rel_rd;
	logic [bbd_pkg::TIME_W-1:0] prs_stamp, rel_stamp;
	logic [bbd_pkg::TIME_W-1:0] prs_diff, rel_diff;
	logic                      prs_held, rel_held;

	logic                      prs_byp_vld_q, rel_byp_vld_q;
	logic [AW-1:0]             prs_byp_addr_q, rel_byp_addr_q;
	logic [bbd_pkg::TIME_W-1:0] prs_byp_q, rel_byp_q;

	// Record a timestamp on an edge of the raw bit
	assign prs_we = ctl.fire && cur && !old;
	assign rel_we = ctl.fire && !cur && old;

	// Zero both stores during the clearing pass, else write the recorded time
	assign prs_ram_we = prs_we || clr;
	assign rel_ram_we = rel_we || clr;
	assign ram_waddr  = clr ? clr_addr : wr_addr;
	assign ram_wdata  = clr ? '0 : ctl.now;

	bbd_ram #(
		.WIDTH (bbd_pkg::TIME_W),
		.DEPTH (BANKS)
	) u_prs_ram (
		.clk   (clk),
		.we    (prs_ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (prs_rd)
	);

	bbd_ram #(
		.WIDTH (bbd_pkg::TIME_W),
		.DEPTH (BANKS)
	) u_rel_ram (
		.clk   (clk),
		.we    (rel_ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rel_rd)
	);

	// Keep the latest write of each store for a read that overlapped it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prs_byp_vld_q <= 1'b0;
			rel_byp_vld_q <= 1'b0;
		end else begin
			if (prs_we) prs_byp_vld_q <= 1'b1;
			if (rel_we) rel_byp_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (prs_we) begin
			prs_byp_addr_q <= wr_addr;
			prs_byp_q      <= ctl.now;
		end
		if (rel_we) begin
			rel_byp_addr_q <= wr_addr;
			rel_byp_q      <= ctl.now;
		end
	end

	// Select the current timestamps
	always_comb begin
		if (prs_byp_vld_q && prs_byp_addr_q == wr_addr) begin
			prs_stamp = prs_byp_q;
		end else begin
			prs_stamp = prs_rd;
		end
		if (rel_byp_vld_q && rel_byp_addr_q == wr_addr) begin
			rel_stamp = rel_byp_q;
		end else begin
			rel_stamp = rel_rd;
		end
	end

	// Compare elapsed time, wrapping, against the hold times
	assign prs_diff = ctl.now - prs_stamp;
	assign rel_diff = ctl.now - rel_stamp;
	assign prs_held = prs_diff >= bbd_pkg::TIME_W'(ctl.press_hold);
	assign rel_held = rel_diff >= bbd_pkg::TIME_W'(ctl.release_hold);

	// Resolve the debounced bit
	always_comb begin
		if (cur != old) begin
			deb_new = deb_old;
		end else if (cur) begin
			deb_new = deb_old | prs_held;
		end else begin
			deb_new = deb_old & !rel_held;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/bank_bit_debouncer.sv -----
// Top level of the bank bit debouncer: input stage, bit lanes, merge and result register.
`default_nettype none

// Takes one bank transaction per clock cycle, sustained while the result side
// does not stall, and presents its debounced word on the result channel from
// the result register: the accepting edge launches the registered read of the
// per-lane timestamp RAMs into stage one, which then resolves all bit lanes in
// parallel and loads the result register when it is free. A transaction to the
// same bank in the following cycle is served by a forward of the last timestamp
// written in each lane. After reset the input stalls while a clearing pass
// zeroes the timestamp RAMs, one bank per cycle. A bank outside the configured
// range changes nothing and reports an all-zero word. Hold times are written
// through the configuration port; the user must write them only while idle, as
// the block itself does not enforce it.
module bank_bit_debouncer #(
	parameter int BANKS         = bbd_pkg::BANKS_DEF,
	parameter int BITS_PER_BANK = bbd_pkg::BITS_PER_BANK_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Configuration
	input  wire logic                              cfg_we,
	input  wire logic [bbd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [bbd_pkg::HOLD_W-1:0]        cfg_wdata,
	// Raw bank channel
	input  wire logic                              item_valid,
	output logic                                   item_stall,
	input  wire logic [bbd_pkg::BANK_W-1:0]        bank,
	input  wire logic [bbd_pkg::WORD_W-1:0]        raw_bits,
	input  wire logic [bbd_pkg::TIME_W-1:0]        now_ms,
	// Debounced result channel
	output logic                                   result_valid,
	input  wire logic                              result_stall,
	output logic      [bbd_pkg::BANK_W-1:0]        bank_out,
	output logic      [bbd_pkg::WORD_W-1:0]        debounced_bits
);

	localparam int AW = (BANKS > 1) ? $clog2(BANKS) : 1;

	logic [bbd_pkg::HOLD_W-1:0] press_hold_q, release_hold_q;

	logic                        clr_q;
	logic [AW-1:0]               clr_addr_q;

	logic                        accept, bank_ok, s1_adv;
	logic                        vld_s1, ok_s1;
	logic [bbd_pkg::BANK_W-1:0]  bank_s1;
	logic [AW-1:0]               addr_s1;
	logic [BITS_PER_BANK-1:0]    raw_s1;
	logic [bbd_pkg::TIME_W-1:0]  now_s1;

	logic [BITS_PER_BANK-1:0]    prev_q [BANKS];
	logic [BITS_PER_BANK-1:0]    deb_q  [BANKS];
	logic [BITS_PER_BANK-1:0]    prev_word, deb_word, deb_new;

	logic                        out_vld_q;
	logic [bbd_pkg::BANK_W-1:0]  bank_out_q;
	logic [bbd_pkg::WORD_W-1:0]  deb_out_q;

	bbd_pkg::lane_ctl_t          ctl;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_hold_q   <= bbd_pkg::HOLD_RESET;
			release_hold_q <= bbd_pkg::HOLD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				bbd_pkg::REG_PRESS_HOLD:   press_hold_q   <= cfg_wdata;
				bbd_pkg::REG_RELEASE_HOLD: release_hold_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Clear the timestamp RAMs one bank per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == AW'(BANKS - 1)) begin
				clr_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	// Handshake: advance stage one when the result register frees up
	assign s1_adv     = vld_s1 && (!out_vld_q || !result_stall);
	assign item_stall = clr_q || (vld_s1 && !s1_adv);
	assign accept     = item_valid && !item_stall;
	assign bank_ok    = 32'(bank) < 32'(BANKS);

	// Capture the transaction into stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (s1_adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1   <= bank_ok;
			bank_s1 <= bank;
			addr_s1 <= AW'(bank);
			raw_s1  <= raw_bits[BITS_PER_BANK-1:0];
			now_s1  <= now_ms;
		end
	end

	// Lane control shared by all bits
	assign ctl.fire         = s1_adv && ok_s1;
	assign ctl.now          = now_s1;
	assign ctl.press_hold   = press_hold_q;
	assign ctl.release_hold = release_hold_q;

	assign prev_word = prev_q[addr_s1];
	assign deb_word  = deb_q[addr_s1];

	// Bit lanes
	for (genvar b = 0; b < BITS_PER_BANK; b++) begin : g_lane
		bbd_lane #(
			.BANKS (BANKS)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.clr      (clr_q),
			.clr_addr (clr_addr_q),
			.rd_en    (accept && bank_ok),
			.rd_addr  (AW'(bank)),
			.wr_addr  (addr_s1),
			.cur      (raw_s1[b]),
			.old      (prev_word[b]),
			.deb_old  (deb_word[b]),
			.deb_new  (deb_new[b])
		);
	end

	// Merge: store the bank's raw and debounced words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BANKS; i++) begin
				prev_q[i] <= '0;
				deb_q[i]  <= '0;
			end
		end else if (ctl.fire) begin
			prev_q[addr_s1] <= raw_s1;
			deb_q[addr_s1]  <= deb_new;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_adv) begin
			out_vld_q <= 1'b1;
		end else if (!result_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			bank_out_q <= bank_s1;
			deb_out_q  <= ok_s1 ? bbd_pkg::WORD_W'(deb_new) : '0;
		end
	end

	assign result_valid   = out_vld_q;
	assign bank_out       = bank_out_q;
	assign debounced_bits = deb_out_q;

endmodule

`default_nettype wire

// ----- rtl/core/bbd_checker.sv -----
// Port-level checks of the bank bit debouncer and their binding.
`default_nettype none

module bbd_checker #(
	parameter int BANKS         = bbd_pkg::BANKS_DEF,
	parameter int BITS_PER_BANK = bbd_pkg::BITS_PER_BANK_DEF
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          cfg_we,
	input wire logic [bbd_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [bbd_pkg::HOLD_W-1:0]    cfg_wdata,
	input wire logic                          item_valid,
	input wire logic                          item_stall,
	input wire logic [bbd_pkg::BANK_W-1:0]    bank,
	input wire logic [bbd_pkg::WORD_W-1:0]    raw_bits,
	input wire logic [bbd_pkg::TIME_W-1:0]    now_ms,
	input wire logic                          result_valid,
	input wire logic                          result_stall,
	input wire logic [bbd_pkg::BANK_W-1:0]    bank_out,
	input wire logic [bbd_pkg::WORD_W-1:0]    debounced_bits
);

	// Hold a stalled result transaction
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(bank_out) && $stable(debounced_bits))
		else $error("stalled result transaction changed");

	// Never back-pressure while a result transaction drains
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall |-> !item_stall)
		else $error("input stalled while result side free");

	// Report an empty word for a bank out of range
	a_bad_bank: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (32'(bank_out) >= 32'(BANKS)) |-> debounced_bits == '0)
		else $error("out-of-range bank reported set bits");

	// Drop bits above the lane count
	a_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (64'(debounced_bits) >> BITS_PER_BANK) == 64'd0)
		else $error("debounced bit set beyond lane count");

endmodule

bind bank_bit_debouncer bbd_checker #(
	.BANKS         (BANKS),
	.BITS_PER_BANK (BITS_PER_BANK)
) u_bbd_checker (.*);

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for the bank bit debouncer: scoreboard class, drivers and checker.

typedef struct packed {
	logic [bbd_pkg::BANK_W-1:0] bank;
	logic [bbd_pkg::WORD_W-1:0] word;
} debounced_result_t;

// Track hold times and per-lane timestamps, predict each bank word and check results in order
class debounce_board;
	localparam int BANKS = bbd_pkg::BANKS_DEF;
	localparam int LANES = bbd_pkg::BITS_PER_BANK_DEF;
	localparam logic [31:0] LANE_MASK = 32'((64'd1 << LANES) - 64'd1);

	logic [bbd_pkg::HOLD_W-1:0] press_hold;
	logic [bbd_pkg::HOLD_W-1:0] release_hold;
	logic [31:0]                last_raw [BANKS];
	logic [31:0]                stable_word [BANKS];
	logic [31:0]                press_stamp [BANKS][LANES];
	logic [31:0]                release_stamp [BANKS][LANES];
	debounced_result_t          due_words [$];
	int unsigned                failures;

	function new();
		press_hold   = bbd_pkg::HOLD_RESET;
		release_hold = bbd_pkg::HOLD_RESET;
		failures     = 0;
		for (int b = 0; b < BANKS; b++) begin
			last_raw[b]    = '0;
			stable_word[b] = '0;
			for (int l = 0; l < LANES; l++) begin
				press_stamp[b][l]   = '0;
				release_stamp[b][l] = '0;
			end
		end
	endfunction

	function void set_hold(logic [bbd_pkg::CFG_IDX_W-1:0] idx,
		logic [bbd_pkg::HOLD_W-1:0] value);
		case (idx)
			bbd_pkg::REG_PRESS_HOLD:   press_hold = value;
			bbd_pkg::REG_RELEASE_HOLD: release_hold = value;
			default: ;
		endcase
	endfunction

	// Advance the bank's lanes for one accepted transaction and queue the word it reports
	function void note_transaction(logic [2:0] b, logic [31:0] raw, logic [31:0] t);
		debounced_result_t due;
		logic [31:0]       cur;
		logic [31:0]       old;
		logic [31:0]       word;
		logic [31:0]       held;
		due.bank = b;
		due.word = '0;
		if (b < BANKS) begin
			cur  = raw & LANE_MASK;
			old  = last_raw[b];
			word = stable_word[b];
			for (int l = 0; l < LANES; l++) begin
				if (cur[l] != old[l]) begin
					if (cur[l])
						press_stamp[b][l] = t;
					else
						release_stamp[b][l] = t;
				end else if (cur[l]) begin
					held = t - press_stamp[b][l];
					if (held >= {16'd0, press_hold})
						word[l] = 1'b1;
				end else begin
					held = t - release_stamp[b][l];
					if (held >= {16'd0, release_hold})
						word[l] = 1'b0;
				end
			end
			stable_word[b] = word & LANE_MASK;
			last_raw[b]    = cur;
			due.word       = stable_word[b];
		end
		due_words.push_back(due);
	endfunction

	// Compare one accepted result with the oldest expected word
	function void check_result(logic [2:0] b, logic [31:0] w);
		debounced_result_t due;
		if (due_words.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("unexpected result: bank %0d word %h", b, w);
		end else begin
			due = due_words.pop_front();
			if (due.bank !== b || due.word !== w) begin
				failures++;
				if (failures <= 10)
					$display("mismatch: expected bank %0d word %h, got bank %0d word %h",
						due.bank, due.word, b, w);
			end
		end
	endfunction

	function int pending();
		return due_words.size();
	endfunction
endclass

module testbench;

	localparam logic [bbd_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [bbd_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [bbd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [bbd_pkg::HOLD_W-1:0]    cfg_wdata = '0;
	logic                          item_valid = 1'b0;
	logic                          item_stall;
	logic [bbd_pkg::BANK_W-1:0]    bank = '0;
	logic [bbd_pkg::WORD_W-1:0]    raw_bits = '0;
	logic [bbd_pkg::TIME_W-1:0]    now_ms = '0;
	logic                          result_valid;
	logic                          result_stall = 1'b0;
	logic [bbd_pkg::BANK_W-1:0]    bank_out;
	logic [bbd_pkg::WORD_W-1:0]    debounced_bits;

	debounce_board board;
	bit            idle_on = 1'b1;
	int            burst_left = 0;
	int            stall_run = 0;
	logic [31:0]   scan_ms = '0;
	logic [31:0]   buttons [bbd_pkg::BANKS_DEF];

	bank_bit_debouncer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.bank           (bank),
		.raw_bits       (raw_bits),
		.now_ms         (now_ms),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.bank_out       (bank_out),
		.debounced_bits (debounced_bits)
	);

	always #1 clk = ~clk;

	// Check accepted results, then pick the next stall level from random runs
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			board.check_result(bank_out, debounced_bits);
		if (!idle_on) begin
			result_stall <= 1'b0;
			stall_run = 0;
		end else if (stall_run > 0) begin
			stall_run--;
		end else begin
			stall_run = $urandom_range(0, 9);
			result_stall <= ($urandom_range(0, 2) == 0);
		end
	end

	// Offer one transaction, with a random gap at the start of each burst while idling is enabled
	task automatic send_bank_word(input logic [2:0] b, input logic [31:0] raw,
		input logic [31:0] t);
		int gap;
		if (idle_on && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(1, 7);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		bank       <= b;
		raw_bits   <= raw;
		now_ms     <= t;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		board.note_transaction(b, raw, t);
		if (burst_left > 0)
			burst_left--;
	endtask

	// Hold the sender until every expected word has arrived, then let the pipeline empty
	task automatic wait_settled();
		item_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_hold(input logic [bbd_pkg::CFG_IDX_W-1:0] idx,
		input logic [bbd_pkg::HOLD_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		board.set_hold(idx, value);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Advance the scan clock, let the buttons drift and bounce, and send one bank word
	task automatic send_scan_item(input int unsigned step_max);
		logic [2:0]  b;
		logic [31:0] raw;
		int          roll;
		int          k;
		roll = $urandom_range(0, 99);
		if (roll < 4)
			b = 3'($urandom_range(bbd_pkg::BANKS_DEF, 7));
		else
			b = 3'($urandom_range(0, bbd_pkg::BANKS_DEF - 1));
		roll = $urandom_range(0, 99);
		if (roll < 2)
			scan_ms = $urandom;
		else if (roll < 10)
			scan_ms = scan_ms + $urandom_range(0, 70000);
		else
			scan_ms = scan_ms + $urandom_range(0, step_max);
		if (b < bbd_pkg::BANKS_DEF) begin
			roll = $urandom_range(0, 99);
			if (roll < 3) begin
				buttons[b] = $urandom;
			end else if (roll < 15) begin
				repeat ($urandom_range(1, 3)) begin
					k = $urandom_range(0, 31);
					buttons[b][k] = ~buttons[b][k];
				end
			end
			raw = buttons[b];
			if ($urandom_range(0, 9) == 0) begin
				k = $urandom_range(0, 31);
				raw[k] = ~raw[k];
			end
		end else begin
			raw = $urandom;
		end
		send_bank_word(b, raw, scan_ms);
	endtask

	// Reprogram both hold times while idle and run one batch of random scans
	task automatic run_phase(input logic [bbd_pkg::HOLD_W-1:0] press,
		input logic [bbd_pkg::HOLD_W-1:0] release_ms,
		input int unsigned step_max, input bit quiet, input int count);
		wait_settled();
		write_hold(bbd_pkg::REG_PRESS_HOLD, press);
		write_hold(bbd_pkg::REG_RELEASE_HOLD, release_ms);
		idle_on <= !quiet;
		for (int n = 0; n < count; n++) begin
			if (n == count / 2)
				wait_settled();
			send_scan_item(step_max);
		end
	endtask

	// Time out a hung run
	initial begin
		#400000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		board = new();
		for (int b = 0; b < bbd_pkg::BANKS_DEF; b++)
			buttons[b] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset hold times: press across the time wrap, then release
		send_bank_word(3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFF8);
		send_bank_word(3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_bank_word(3'd0, 32'hFFFF_FFFF, 32'h0000_0002);
		send_bank_word(3'd4, 32'h8000_0001, 32'd3);
		send_bank_word(3'd4, 32'h8000_0001, 32'd13);
		// Banks beyond the last report zero and change nothing
		send_bank_word(3'd7, 32'hFFFF_FFFF, 32'd13);
		send_bank_word(3'd5, 32'h1234_5678, 32'd14);
		send_bank_word(3'd6, 32'hFFFF_FFFF, 32'd14);
		send_bank_word(3'd0, 32'h0000_0000, 32'd20);
		send_bank_word(3'd0, 32'h0000_0000, 32'd30);
		send_bank_word(3'd1, 32'h0000_0000, 32'd30);
		// Every lane toggles at once
		send_bank_word(3'd2, 32'hA5A5_5A5A, 32'd40);
		send_bank_word(3'd2, 32'h5A5A_A5A5, 32'd45);
		send_bank_word(3'd2, 32'h5A5A_A5A5, 32'd60);

		// Spare indexes are ignored; zero press hold, longest release hold
		wait_settled();
		write_hold(REG_SPARE_A, 16'hFFFF);
		write_hold(REG_SPARE_B, 16'h1234);
		write_hold(bbd_pkg::REG_PRESS_HOLD, 16'd0);
		write_hold(bbd_pkg::REG_RELEASE_HOLD, 16'hFFFF);
		send_bank_word(3'd3, 32'hFFFF_FFFF, 32'd100);
		send_bank_word(3'd3, 32'hFFFF_FFFF, 32'd100);
		send_bank_word(3'd3, 32'h0000_0000, 32'd101);
		send_bank_word(3'd3, 32'h0000_0000, 32'd200);
		send_bank_word(3'd3, 32'h0000_0000, 32'd101 + 32'd65535);

		// Longest press hold, zero release hold: hit the threshold exactly
		wait_settled();
		write_hold(bbd_pkg::REG_PRESS_HOLD, 16'hFFFF);
		write_hold(bbd_pkg::REG_RELEASE_HOLD, 16'd0);
		send_bank_word(3'd1, 32'h0000_FFFF, 32'h0002_0000);
		send_bank_word(3'd1, 32'h0000_FFFF, 32'h0002_FFFE);
		send_bank_word(3'd1, 32'h0000_FFFF, 32'h0002_FFFF);
		send_bank_word(3'd1, 32'h0000_0000, 32'h0002_FFFF);
		send_bank_word(3'd1, 32'h0000_0000, 32'h0002_FFFF);
		scan_ms = 32'h0002_FFFF;

		run_phase(16'd0, 16'd0, 4, 1'b0, 150);
		run_phase(16'hFFFF, 16'hFFFF, 3000, 1'b0, 150);
		run_phase(16'd3, 16'd25, 8, 1'b1, 150);
		run_phase(16'd25, 16'd3, 8, 1'b0, 150);
		run_phase(16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)), 12, 1'b0, 150);
		run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 5000,
			1'b0, 150);
		run_phase(16'd10, 16'd10, 6, 1'b0, 150);

		wait_settled();
		repeat (8) @(posedge clk);
		if (board.failures == 0 && board.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
